// ===== rtl/register_machine_executor_assert.svh =====
// Assertion macros for the register machine executor controller
`ifndef REGISTER_MACHINE_EXECUTOR_ASSERT_SVH
`define REGISTER_MACHINE_EXECUTOR_ASSERT_SVH

// Implication checked on every rising clock edge outside reset
`define RME_ASSERT_IMP(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Implication checked in the cycle after the trigger
`define RME_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ===== rtl/rme_pkg.sv =====
// Package: opcodes, status codes, controller states and command/status structs
`timescale 1ns / 1ps
package rme_pkg;

   typedef enum logic [4:0] {
      OP_LI    = 5'd0,
      OP_LIL   = 5'd1,
      OP_LIH   = 5'd2,
      OP_LOAD  = 5'd3,
      OP_STORE = 5'd4,
      OP_ADD   = 5'd5,
      OP_SUB   = 5'd6,
      OP_MUL   = 5'd7,
      OP_DIV   = 5'd8,
      OP_CMP   = 5'd9,
      OP_JMP   = 5'd10,
      OP_JE    = 5'd11,
      OP_JNE   = 5'd12,
      OP_JG    = 5'd13,
      OP_JL    = 5'd14,
      OP_JGE   = 5'd15,
      OP_JLE   = 5'd16,
      OP_PRINT = 5'd17
   } opcode_type;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_DIV0  = 2'd1;
   localparam logic [1:0] ST_BADOP = 2'd2;
   localparam logic [1:0] ST_RANGE = 2'd3;

   localparam int DataWidth = 32;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_EXEC,
      S_DIV,
      S_WRITE,
      S_OUT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;    // latch request beat, start register/memory reads
      logic exec;       // evaluate instruction on read operands
      logic div_start;  // load divider
      logic commit;     // write back state and result
      logic rsp_taken;  // result beat accepted
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic need_div;   // instruction is a valid division
      logic div_busy;
   } sts_type;

endpackage

// ===== rtl/rme_divider.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero
`timescale 1ns / 1ps
module rme_divider
   import rme_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DataWidth-1:0] dividend,
   input  logic [DataWidth-1:0] divisor,
   output logic                 busy,
   output logic [DataWidth-1:0] quotient
);
   localparam int CntW = $clog2(DataWidth + 1);

   logic [DataWidth-1:0] rem_ff, rem_in;
   logic [DataWidth-1:0] quo_ff, quo_in;
   logic [DataWidth-1:0] dvs_ff, dvs_in;
   logic                 neg_ff, neg_in;
   logic [CntW-1:0]      cnt_ff, cnt_in;
   logic [DataWidth:0]   trial;

   // Control: step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   // Restoring division step on magnitudes
   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      trial  = {rem_ff, quo_ff[DataWidth-1]} - {1'b0, dvs_ff};
      if (start) begin
         rem_in = '0;
         quo_in = dividend[DataWidth-1] ? (~dividend + 1'b1) : dividend;
         dvs_in = divisor[DataWidth-1] ? (~divisor + 1'b1) : divisor;
         neg_in = dividend[DataWidth-1] ^ divisor[DataWidth-1];
         cnt_in = CntW'(DataWidth);
      end else if (cnt_ff != '0) begin
         if (!trial[DataWidth]) begin
            rem_in = trial[DataWidth-1:0];
            quo_in = {quo_ff[DataWidth-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DataWidth-2:0], quo_ff[DataWidth-1]};
            quo_in = {quo_ff[DataWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
      end
   end

   assign busy     = (cnt_ff != '0);
   assign quotient = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

endmodule

// ===== rtl/rme_datapath.sv =====
// Datapath: register file, data memory, flags, program counter, ALU and result register
`timescale 1ns / 1ps
module rme_datapath
   import rme_pkg::*;
#(
   parameter int NUM_REGS      = 32,
   parameter int DATA_WORDS    = 256,
   parameter int PROGRAM_WORDS = 65536
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output sts_type              sts,
   input  logic [15:0]          program_length,
   input  logic [4:0]           req_op,
   input  logic [15:0]          req_dest,
   input  logic [7:0]           req_left,
   input  logic [15:0]          req_right,
   input  logic [31:0]          req_immediate,
   output logic [31:0]          rsp_result_value,
   output logic                 rsp_printed,
   output logic [15:0]          rsp_next_pc,
   output logic                 rsp_done_res,
   output logic [1:0]           rsp_status,
   output logic                 rsp_zero_out,
   output logic                 rsp_sign_out
);
   localparam int RegAw = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
   localparam int MemAw = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
   localparam logic [16:0] EffLen17 = (PROGRAM_WORDS >= 65536) ? 17'd65536
                                      : 17'(PROGRAM_WORDS);

   // Storage: valid bits stand in for the reset value of every entry
   logic [31:0] regs_mem [NUM_REGS];
   logic [31:0] data_mem [DATA_WORDS];
   logic [NUM_REGS-1:0]   rvalid_ff;
   logic [DATA_WORDS-1:0] dvalid_ff;

   // Architectural state
   logic [15:0] pc_ff;
   logic [31:0] last_ff;
   logic        zf_ff, sf_ff;

   // Latched request
   logic [4:0]  op_ff;
   logic [15:0] dest_ff, right_ff;
   logic [7:0]  left_ff;
   logic [31:0] imm_ff;

   // Registered read data
   logic [31:0] rd_a_ff, rd_b_ff, rd_d_ff, rd_m_ff;
   logic        va_ff, vb_ff, vd_ff, vm_ff;

   // Execute stage results
   logic [31:0] res_ff, res_in;
   logic [1:0]  stat_ff, stat_in;
   logic        wreg_ff, wreg_in, wmem_ff, wmem_in, wflag_ff, wflag_in;
   logic        wlast_ff, wlast_in, prn_ff, prn_in;
   logic [16:0] next_ff, next_in;
   logic        ended_ff, ended_in;
   logic        isdiv_ff, isdiv_in;

   logic [31:0] opa, opb, opd, opm;
   logic        dr, lr, rr, dm, rm;
   logic [16:0] len17;
   logic        take;
   logic [31:0] diff;
   logic        div_busy;
   logic [31:0] div_q;

   // Output register
   logic [31:0] o_val_ff;
   logic        o_prn_ff, o_done_ff, o_zf_ff, o_sf_ff;
   logic [15:0] o_pc_ff;
   logic [1:0]  o_st_ff;

   assign len17 = ({1'b0, program_length} < EffLen17) ? {1'b0, program_length} : EffLen17;
   assign dr = ({16'd0, dest_ff} < 32'(NUM_REGS));
   assign lr = ({24'd0, left_ff} < 32'(NUM_REGS));
   assign rr = ({16'd0, right_ff} < 32'(NUM_REGS));
   assign dm = ({16'd0, dest_ff} < 32'(DATA_WORDS));
   assign rm = ({16'd0, right_ff} < 32'(DATA_WORDS));

   assign opa = va_ff ? rd_a_ff : '0;
   assign opb = vb_ff ? rd_b_ff : '0;
   assign opd = vd_ff ? rd_d_ff : '0;
   assign opm = vm_ff ? rd_m_ff : '0;

   // Request latch
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_op;
         dest_ff  <= req_dest;
         left_ff  <= req_left;
         right_ff <= req_right;
         imm_ff   <= req_immediate;
      end
   end

   // Register file and data memory reads (registered)
   always_ff @(posedge clock) begin
      rd_a_ff <= regs_mem[left_ff[RegAw-1:0]];
      rd_b_ff <= regs_mem[right_ff[RegAw-1:0]];
      rd_d_ff <= regs_mem[dest_ff[RegAw-1:0]];
      rd_m_ff <= data_mem[right_ff[MemAw-1:0]];
      va_ff   <= rvalid_ff[left_ff[RegAw-1:0]];
      vb_ff   <= rvalid_ff[right_ff[RegAw-1:0]];
      vd_ff   <= rvalid_ff[dest_ff[RegAw-1:0]];
      vm_ff   <= dvalid_ff[right_ff[MemAw-1:0]];
   end

   // Writes
   always_ff @(posedge clock) begin
      if (cmd.commit && wreg_ff) begin
         regs_mem[dest_ff[RegAw-1:0]] <= res_ff;
      end
      if (cmd.commit && wmem_ff) begin
         data_mem[dest_ff[MemAw-1:0]] <= res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rvalid_ff <= '0;
         dvalid_ff <= '0;
      end else begin
         if (cmd.commit && wreg_ff) rvalid_ff[dest_ff[RegAw-1:0]] <= 1'b1;
         if (cmd.commit && wmem_ff) dvalid_ff[dest_ff[MemAw-1:0]] <= 1'b1;
      end
   end

   assign diff = opa - opb;

   // Execute: decode, range checks, ALU, branch
   always_comb begin
      res_in   = '0;
      stat_in  = ST_OK;
      wreg_in  = 1'b0;
      wmem_in  = 1'b0;
      wflag_in = 1'b0;
      wlast_in = 1'b0;
      prn_in   = 1'b0;
      isdiv_in = 1'b0;
      take     = 1'b0;
      next_in  = {1'b0, pc_ff} + 17'd1;
      case (op_ff)
         OP_LI, OP_LIL, OP_LIH: begin
            if (!dr) stat_in = ST_RANGE;
            else begin
               wreg_in = 1'b1;
               wlast_in = 1'b1;
               if (op_ff == OP_LI) res_in = imm_ff;
               else if (op_ff == OP_LIL) res_in = {16'd0, imm_ff[15:0]};
               else res_in = opd + {imm_ff[15:0], 16'd0};
            end
         end
         OP_LOAD: begin
            if (!dr || !rm) stat_in = ST_RANGE;
            else begin
               wreg_in = 1'b1; wlast_in = 1'b1; res_in = opm;
            end
         end
         OP_STORE: begin
            if (!dm || !rr) stat_in = ST_RANGE;
            else begin
               wmem_in = 1'b1; wlast_in = 1'b1; res_in = opb;
            end
         end
         OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
            if (!dr || !lr || !rr) stat_in = ST_RANGE;
            else if (op_ff == OP_DIV && opb == '0) stat_in = ST_DIV0;
            else begin
               wreg_in = 1'b1; wlast_in = 1'b1;
               if (op_ff == OP_ADD) res_in = opa + opb;
               else if (op_ff == OP_SUB) res_in = diff;
               else if (op_ff == OP_MUL) res_in = opa * opb;
               else isdiv_in = 1'b1;
            end
         end
         OP_CMP: begin
            if (!lr || !rr) stat_in = ST_RANGE;
            else begin
               wflag_in = 1'b1; wlast_in = 1'b1; res_in = diff;
            end
         end
         OP_JMP, OP_JE, OP_JNE, OP_JG, OP_JL, OP_JGE, OP_JLE: begin
            case (op_ff)
               OP_JMP:  take = 1'b1;
               OP_JE:   take = zf_ff;
               OP_JNE:  take = !zf_ff;
               OP_JG:   take = !zf_ff && !sf_ff;
               OP_JL:   take = sf_ff;
               OP_JGE:  take = !sf_ff;
               default: take = zf_ff || sf_ff;
            endcase
            if (take) next_in = {1'b0, dest_ff};
         end
         OP_PRINT: begin
            prn_in = 1'b1; wlast_in = 1'b1;
            res_in = dr ? opd : '0;
         end
         default: stat_in = ST_BADOP;
      endcase
      ended_in = (stat_in != ST_OK) || (next_in >= len17);
      // Program empty or already past its end: the beat writes no register, memory or flags and ends the run
      if ({1'b0, pc_ff} >= len17) begin
         stat_in  = ST_OK;
         wreg_in  = 1'b0;
         wmem_in  = 1'b0;
         wflag_in = 1'b0;
         wlast_in = 1'b0;
         prn_in   = 1'b0;
         isdiv_in = 1'b0;
         ended_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         res_ff   <= res_in;
         stat_ff  <= stat_in;
         wreg_ff  <= wreg_in;
         wmem_ff  <= wmem_in;
         wflag_ff <= wflag_in;
         wlast_ff <= wlast_in;
         prn_ff   <= prn_in;
         next_ff  <= next_in;
         ended_ff <= ended_in;
         isdiv_ff <= isdiv_in;
      end else if (isdiv_ff && !div_busy && !cmd.div_start && !cmd.commit) begin
         res_ff <= div_q;
      end
   end

   rme_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (opa),
      .divisor  (opb),
      .busy     (div_busy),
      .quotient (div_q)
   );

   assign sts.need_div = isdiv_ff;
   assign sts.div_busy = div_busy;

   // Commit architectural state and load output register
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= '0;
         last_ff <= '0;
         zf_ff   <= 1'b0;
         sf_ff   <= 1'b0;
      end else if (cmd.capture && ({1'b0, pc_ff} >= len17)) begin
         last_ff <= '0;
      end else if (cmd.commit) begin
         if (ended_ff) begin
            pc_ff   <= '0;
            last_ff <= '0;
         end else begin
            pc_ff <= next_ff[15:0];
            if (wlast_ff) last_ff <= res_ff;
         end
         if (wflag_ff && stat_ff == ST_OK) begin
            zf_ff <= (res_ff == '0);
            sf_ff <= res_ff[31];
         end
      end
   end

   logic        inactive_ff;
   always_ff @(posedge clock) begin
      if (cmd.capture) inactive_ff <= ({1'b0, pc_ff} >= len17);
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         o_prn_ff  <= inactive_ff ? 1'b0 : prn_ff;
         o_done_ff <= inactive_ff ? 1'b1 : ended_ff;
         o_pc_ff   <= (inactive_ff || ended_ff) ? 16'd0 : next_ff[15:0];
         o_st_ff   <= inactive_ff ? ST_OK : stat_ff;
         o_val_ff  <= inactive_ff ? 32'd0 : (wlast_ff ? res_ff : last_ff);
         o_zf_ff   <= (!inactive_ff && wflag_ff && stat_ff == ST_OK) ? (res_ff == '0) : zf_ff;
         o_sf_ff   <= (!inactive_ff && wflag_ff && stat_ff == ST_OK) ? res_ff[31] : sf_ff;
      end
   end

   assign rsp_result_value = o_val_ff;
   assign rsp_printed      = o_prn_ff;
   assign rsp_next_pc      = o_pc_ff;
   assign rsp_done_res     = o_done_ff;
   assign rsp_status       = o_st_ff;
   assign rsp_zero_out     = o_zf_ff;
   assign rsp_sign_out     = o_sf_ff;

endmodule

// ===== rtl/rme_control.sv =====
// Controller: sequences capture, operand read, execute, divide, commit and response
`timescale 1ns / 1ps
module rme_control
   import rme_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd,
   input  sts_type sts
);
   state_type state_ff, state_in;
   logic      div_wait_ff, div_wait_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         div_wait_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         div_wait_ff <= div_wait_in;
      end
   end

   // Next state
   always_comb begin
      state_in    = state_ff;
      div_wait_in = div_wait_ff;
      case (state_ff)
         S_IDLE: if (req_valid) state_in = S_READ;
         S_READ: state_in = S_EXEC;
         S_EXEC: state_in = S_DIV;
         S_DIV: begin
            if (!sts.need_div) state_in = S_WRITE;
            else if (!div_wait_ff) div_wait_in = 1'b1;
            else if (!sts.div_busy) begin
               div_wait_in = 1'b0;
               state_in    = S_WRITE;
            end
         end
         S_WRITE: begin
            if (!sts.need_div || !div_wait_ff) state_in = S_OUT;
         end
         S_OUT: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd           = '0;
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         S_EXEC:  cmd.exec = 1'b1;
         S_DIV:   cmd.div_start = sts.need_div && !div_wait_ff;
         S_WRITE: cmd.commit = 1'b1;
         S_OUT: begin
            rsp_valid     = 1'b1;
            cmd.rsp_taken = rsp_ready;
         end
         default: ;
      endcase
   end

   `include "register_machine_executor_assert.svh"

   `RME_ASSERT_IMP(a_ready_idle, clock, reset, req_ready, !rsp_valid, "ready while result pending")
   `RME_ASSERT_NEXT(a_commit_out, clock, reset, cmd.commit, rsp_valid, "commit not followed by result")
   `RME_ASSERT_IMP(a_one_cmd, clock, reset, 1'b1, $onehot0({cmd.capture, cmd.exec, cmd.div_start, cmd.commit}), "overlapping commands")

endmodule

// ===== rtl/register_machine_executor.sv =====
// Top level: register machine executor, controller plus datapath
//
//  channel | direction | handshake             | payload
//  req     | in        | req_valid/req_ready   | op, dest, left, right, immediate
//  rsp     | out       | rsp_valid/rsp_ready   | result_value .. sign_out
//  csr     | in        | csr_valid/csr_ready   | program_length
//
// The result is valid once the read, execute, divide check and commit states
// have followed the request beat; DIV waits in the divide state until the
// bit-serial divider is done. The block takes one instruction at a time; the
// next beat is accepted once the result beat has been taken. Synchronous active
// high reset clears control, program counter, flags and valid bits of the
// register file and data memory.
`timescale 1ns / 1ps
module register_machine_executor
   import rme_pkg::*;
#(
   parameter int NUM_REGS      = 32,
   parameter int DATA_WORDS    = 256,
   parameter int PROGRAM_WORDS = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_program_length,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [4:0]  req_op,
   input  logic [15:0] req_dest,
   input  logic [7:0]  req_left,
   input  logic [15:0] req_right,
   input  logic [31:0] req_immediate,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_result_value,
   output logic        rsp_printed,
   output logic [15:0] rsp_next_pc,
   output logic        rsp_done_res,
   output logic [1:0]  rsp_status,
   output logic        rsp_zero_out,
   output logic        rsp_sign_out
);
   cmd_type     cmd;
   sts_type     sts;
   logic [15:0] plen_ff;

   // Configuration register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) plen_ff <= '0;
      else if (csr_valid) plen_ff <= csr_program_length;
   end

   rme_control u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   rme_datapath #(
      .NUM_REGS      (NUM_REGS),
      .DATA_WORDS    (DATA_WORDS),
      .PROGRAM_WORDS (PROGRAM_WORDS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .program_length   (plen_ff),
      .req_op           (req_op),
      .req_dest         (req_dest),
      .req_left         (req_left),
      .req_right        (req_right),
      .req_immediate    (req_immediate),
      .rsp_result_value (rsp_result_value),
      .rsp_printed      (rsp_printed),
      .rsp_next_pc      (rsp_next_pc),
      .rsp_done_res     (rsp_done_res),
      .rsp_status       (rsp_status),
      .rsp_zero_out     (rsp_zero_out),
      .rsp_sign_out     (rsp_sign_out)
   );

endmodule

// ===== bench/tb_register_machine_executor.sv =====
// Testbench for the register machine executor: random and directed programs
`timescale 1ns / 1ps
module tb_register_machine_executor;
   import rme_pkg::*;

   localparam int NREGS = 32;
   localparam int NWORDS = 256;
   localparam int WATCH_LIMIT = 20000;

   typedef struct {
      logic [31:0] value;
      logic        printed;
      logic [15:0] next_pc;
      logic        done;
      logic [1:0]  status;
      logic        zero;
      logic        sign;
   } result_type;

   // Scoreboard: machine state copy and queue of expected results
   class machine_scoreboard;
      logic [31:0] regs[NREGS];
      logic [31:0] mem[NWORDS];
      logic [15:0] pc;
      logic [31:0] last;
      logic        zf, sf;
      logic [15:0] length;
      result_type  pending[$];
      int          errors;
      int          checked;

      function void clear();
         foreach (regs[i]) regs[i] = '0;
         foreach (mem[i]) mem[i] = '0;
         pc = '0; last = '0; zf = 0; sf = 0; length = '0;
         errors = 0; checked = 0;
      endfunction

      function logic [31:0] quotient(logic [31:0] a, logic [31:0] b);
         logic [31:0] ma, mb, q;
         ma = a[31] ? -a : a;
         mb = b[31] ? -b : b;
         q = ma / mb;
         return (a[31] != b[31]) ? -q : q;
      endfunction

      // Work out the result of one accepted instruction
      function void note_instruction(logic [4:0] op, logic [15:0] dest, logic [7:0] lft,
                                     logic [15:0] rgt, logic [31:0] imm);
         result_type r;
         logic [16:0] nxt;
         logic dr, lr, rr, take, done;
         logic [31:0] a, b, v;
         r.status = ST_OK; r.printed = 0;
         nxt = {1'b0, pc} + 17'd1;
         done = 0;
         dr = dest < NREGS; lr = lft < NREGS; rr = rgt < NREGS;
         if (pc >= length) begin
            last = '0;
            done = 1;
         end else begin
            case (op)
               OP_LI, OP_LIL, OP_LIH: begin
                  if (!dr) r.status = ST_RANGE;
                  else begin
                     if (op == OP_LI) regs[dest] = imm;
                     else if (op == OP_LIL) regs[dest] = {16'd0, imm[15:0]};
                     else regs[dest] = regs[dest] + {imm[15:0], 16'd0};
                     last = regs[dest];
                  end
               end
               OP_LOAD: begin
                  if (!dr || rgt >= NWORDS) r.status = ST_RANGE;
                  else begin
                     regs[dest] = mem[rgt];
                     last = regs[dest];
                  end
               end
               OP_STORE: begin
                  if (dest >= NWORDS || !rr) r.status = ST_RANGE;
                  else begin
                     mem[dest] = regs[rgt];
                     last = mem[dest];
                  end
               end
               OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                  if (!dr || !lr || !rr) r.status = ST_RANGE;
                  else begin
                     a = regs[lft]; b = regs[rgt];
                     if (op == OP_ADD) v = a + b;
                     else if (op == OP_SUB) v = a - b;
                     else if (op == OP_MUL) v = a * b;
                     else if (b == 0) r.status = ST_DIV0;
                     else v = quotient(a, b);
                     if (r.status == ST_OK) begin
                        regs[dest] = v;
                        last = v;
                     end
                  end
               end
               OP_CMP: begin
                  if (!lr || !rr) r.status = ST_RANGE;
                  else begin
                     v = regs[lft] - regs[rgt];
                     zf = (v == 0);
                     sf = v[31];
                     last = v;
                  end
               end
               OP_JMP, OP_JE, OP_JNE, OP_JG, OP_JL, OP_JGE, OP_JLE: begin
                  case (op)
                     OP_JMP: take = 1;
                     OP_JE: take = zf;
                     OP_JNE: take = !zf;
                     OP_JG: take = !zf && !sf;
                     OP_JL: take = sf;
                     OP_JGE: take = !sf;
                     default: take = zf || sf;
                  endcase
                  if (take) nxt = {1'b0, dest};
               end
               OP_PRINT: begin
                  r.printed = 1;
                  last = dr ? regs[dest] : '0;
               end
               default: r.status = ST_BADOP;
            endcase
            if (r.status != ST_OK || nxt >= {1'b0, length}) done = 1;
         end
         r.value = last;
         r.next_pc = done ? 16'd0 : nxt[15:0];
         r.done = done;
         r.zero = zf;
         r.sign = sf;
         if (done) begin
            pc = '0;
            last = '0;
         end else begin
            pc = nxt[15:0];
         end
         pending = {pending, r};
      endfunction

      task check_result(result_type got);
         result_type want;
         if (pending.size() == 0) begin
            report_error("result beat with nothing expected");
            return;
         end
         want = pending.pop_front();
         checked++;
         if (got.value !== want.value) report_error($sformatf("value %h want %h",
                                                    got.value, want.value));
         if (got.printed !== want.printed) report_error("printed mismatch");
         if (got.next_pc !== want.next_pc) report_error($sformatf("next_pc %0d want %0d",
                                                        got.next_pc, want.next_pc));
         if (got.done !== want.done) report_error("done mismatch");
         if (got.status !== want.status) report_error($sformatf("status %0d want %0d",
                                                       got.status, want.status));
         if (got.zero !== want.zero) report_error("zero flag mismatch");
         if (got.sign !== want.sign) report_error("sign flag mismatch");
      endtask

      task report_error(string msg);
         errors++;
         if (errors <= 30) $display("[%0t] mismatch: %s", $realtime, msg);
      endtask
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [15:0] csr_program_length = '0;
   logic        req_valid = 0;
   logic        req_ready;
   logic [4:0]  req_op = '0;
   logic [15:0] req_dest = '0;
   logic [7:0]  req_left = '0;
   logic [15:0] req_right = '0;
   logic [31:0] req_immediate = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [31:0] rsp_result_value;
   logic        rsp_printed;
   logic [15:0] rsp_next_pc;
   logic        rsp_done_res;
   logic [1:0]  rsp_status;
   logic        rsp_zero_out;
   logic        rsp_sign_out;

   machine_scoreboard board;
   int send_idle_pct = 9;
   int recv_idle_pct = 62;
   bit hold_off = 0;
   int sent_count = 0;
   int watch_count = 0;

   always #4 clock = ~clock;

   register_machine_executor i_dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_program_length(csr_program_length),
      .req_valid(req_valid), .req_ready(req_ready), .req_op(req_op), .req_dest(req_dest),
      .req_left(req_left), .req_right(req_right), .req_immediate(req_immediate),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_result_value(rsp_result_value),
      .rsp_printed(rsp_printed), .rsp_next_pc(rsp_next_pc), .rsp_done_res(rsp_done_res),
      .rsp_status(rsp_status), .rsp_zero_out(rsp_zero_out), .rsp_sign_out(rsp_sign_out)
   );

   initial board = new();

   // Result side: sample at rising edge, change ready at falling edge
   always @(posedge clock) begin
      result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.value = rsp_result_value; got.printed = rsp_printed;
         got.next_pc = rsp_next_pc; got.done = rsp_done_res; got.status = rsp_status;
         got.zero = rsp_zero_out; got.sign = rsp_sign_out;
         board.check_result(got);
      end
   end

   always @(negedge clock)
      rsp_ready <= !reset && !hold_off && ($urandom_range(99) >= recv_idle_pct);

   // Watchdog on cycles with no beat on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         watch_count <= 0;
      end else begin
         watch_count <= watch_count + 1;
         if (watch_count >= WATCH_LIMIT) begin
            $display("watchdog: no progress");
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   task automatic write_length(logic [15:0] len);
      @(negedge clock);
      csr_valid <= 1;
      csr_program_length <= len;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.length = len;
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic send_instruction(logic [4:0] op, logic [15:0] dest, logic [7:0] lft,
                                   logic [15:0] rgt, logic [31:0] imm);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_valid <= 1;
      req_op <= op; req_dest <= dest; req_left <= lft;
      req_right <= rgt; req_immediate <= imm;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_instruction(op, dest, lft, rgt, imm);
      sent_count++;
      @(negedge clock);
      req_valid <= 0;
   endtask

   task automatic drain();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // Mostly in-range operands, sometimes full-width noise
   function automatic logic [15:0] pick_index16();
      int k;
      k = $urandom_range(99);
      if (k < 80) return 16'($urandom_range(NREGS - 1));
      if (k < 90) return 16'($urandom_range(NWORDS - 1));
      return 16'($urandom);
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'($urandom_range(20));
         3: return 32'h7FFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic random_item(logic [15:0] len);
      logic [4:0] op;
      logic [15:0] dest, rgt;
      logic [7:0] lft;
      int k;
      k = $urandom_range(99);
      if (k < 4) op = 5'($urandom_range(18, 31));
      else op = 5'($urandom_range(0, 17));
      dest = pick_index16();
      rgt = pick_index16();
      lft = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(NREGS - 1));
      if (op == OP_STORE || op == OP_LOAD) begin
         if ($urandom_range(9) != 0) begin
            if (op == OP_STORE) dest = 16'($urandom_range(NWORDS - 1));
            else rgt = 16'($urandom_range(NWORDS - 1));
         end
      end
      if (op >= OP_JMP && op <= OP_JLE && $urandom_range(9) != 0)
         dest = (len == 0) ? 16'd0 : 16'($urandom_range(len - 1));
      send_instruction(op, dest, lft, rgt, pick_value());
   endtask

   initial begin
      logic [15:0] lengths[5];
      int phase;
      board.clear();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Empty program: everything ignored
      send_instruction(OP_LI, 16'd1, 8'd0, 16'd0, 32'h1234_5678);
      drain();
      write_length(16'hFFFF);
      // Directed: extremes, each op, special cases
      send_instruction(OP_LI, 16'd1, 8'd0, 16'd0, 32'h8000_0000);
      send_instruction(OP_LI, 16'd2, 8'd0, 16'd0, 32'hFFFF_FFFF);
      send_instruction(OP_DIV, 16'd3, 8'd1, 16'd2, 32'd0);      // overflow wrap
      send_instruction(OP_DIV, 16'd3, 8'd1, 16'd0, 32'd0);      // divide by zero
      send_instruction(OP_LIL, 16'd31, 8'd0, 16'd0, 32'hABCD_FFFF);
      send_instruction(OP_LIH, 16'd31, 8'd0, 16'd0, 32'h0000_FFFF);
      send_instruction(OP_STORE, 16'd255, 8'd0, 16'd31, 32'd0);
      send_instruction(OP_LOAD, 16'd4, 8'd0, 16'd255, 32'd0);
      send_instruction(OP_ADD, 16'd5, 8'd1, 16'd2, 32'd0);
      send_instruction(OP_SUB, 16'd6, 8'd4, 16'd1, 32'd0);
      send_instruction(OP_MUL, 16'd7, 8'd2, 16'd2, 32'd0);
      send_instruction(OP_CMP, 16'd0, 8'd1, 16'd1, 32'd0);
      send_instruction(OP_JE, 16'd20, 8'd0, 16'd0, 32'd0);
      send_instruction(OP_CMP, 16'd0, 8'd1, 16'd2, 32'd0);
      send_instruction(OP_JL, 16'd30, 8'd0, 16'd0, 32'd0);
      send_instruction(OP_JLE, 16'd40, 8'd0, 16'd0, 32'd0);
      send_instruction(OP_JG, 16'd41, 8'd0, 16'd0, 32'd0);
      send_instruction(OP_JGE, 16'd42, 8'd0, 16'd0, 32'd0);
      send_instruction(OP_JNE, 16'd43, 8'd0, 16'd0, 32'd0);
      send_instruction(OP_PRINT, 16'hFFFF, 8'd0, 16'd0, 32'd0); // print out of range
      send_instruction(OP_PRINT, 16'd5, 8'd0, 16'd0, 32'd0);
      send_instruction(OP_LI, 16'hFFFF, 8'hFF, 16'hFFFF, 32'd0); // range error
      send_instruction(5'd31, 16'd0, 8'd0, 16'd0, 32'd0);         // bad opcode
      send_instruction(OP_JMP, 16'hFFFF, 8'd0, 16'd0, 32'd0);     // jump past end
      drain();

      // Random phases over several program lengths and idling profiles
      lengths = '{16'd1, 16'd6, 16'd25, 16'd200, 16'hFFFF};
      for (phase = 0; phase < 15; phase++) begin
         if (phase == 5) begin send_idle_pct = 62; recv_idle_pct = 9; end
         if (phase == 10) begin send_idle_pct = 0; recv_idle_pct = 0; end
         write_length(lengths[phase % 5]);
         if (phase == 2) begin
            // Long receiver hold-off while the sender keeps offering
            fork
               begin
                  hold_off = 1;
                  repeat (300) @(posedge clock);
                  hold_off = 0;
               end
               repeat (10) random_item(lengths[phase % 5]);
            join
         end
         repeat (108) random_item(lengths[phase % 5]);
         // Sender pauses until every result has come
         drain();
      end

      $display("covered %0d instructions, %0d results checked, program lengths 0 to 65535",
               sent_count, board.checked);
      $display("all opcodes incl. unknown ones, range, div-by-zero and jump-end cases");
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
